// File: sv/rcbm_pkg.sv
// Shared types, access codes and decode helpers for the region checked byte memory.
`default_nettype none

package rcbm_pkg;

    // Access codes carried in the request.
    typedef enum logic [2:0] {
        MODE_LBU = 3'd0,
        MODE_LHU = 3'd1,
        MODE_LW  = 3'd2,
        MODE_LB  = 3'd3,
        MODE_LH  = 3'd4,
        MODE_SB  = 3'd5,
        MODE_SH  = 3'd6,
        MODE_SW  = 3'd7
    } t_mode;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_DONE
    } t_state;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GP_START   = 3'd3;

    // Stream widths: request is mode, address, write data padded to bytes.
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 32;

    // Values returned by a refused load.
    localparam logic [31:0] REFUSE_BYTE = 32'h0000_00ff;
    localparam logic [31:0] REFUSE_HALF = 32'h0000_ffff;
    localparam logic [31:0] REFUSE_WORD = 32'hffff_ffff;

    // Access size in bytes minus one.
    function automatic logic [1:0] mode_size_m1(input t_mode mode);
        logic [1:0] sz;
        case (mode)
            MODE_LBU, MODE_LB, MODE_SB: sz = 2'd0;
            MODE_LHU, MODE_LH, MODE_SH: sz = 2'd1;
            MODE_LW,  MODE_SW:          sz = 2'd3;
            default:                    sz = 2'd0;
        endcase
        return sz;
    endfunction

    function automatic logic mode_is_store(input t_mode mode);
        return (mode == MODE_SB) || (mode == MODE_SH) || (mode == MODE_SW);
    endfunction

endpackage

`default_nettype wire

// File: sv/region_checked_byte_memory.sv
// Top level of the region checked byte memory: controller, region check and byte RAM.
//
//  channel   direction  handshake                contents
//  s_axis    in         tvalid / tready          request: mode, address, is_data, write_data
//  m_axis    out        tvalid / tready          result: read_data, accepted
//  cfg       in         i_cfg_we (no wait)       region registers by index
//
// A request is taken in, goes through the region check, moves its bytes through
// the single port of the byte-wide RAM one byte per cycle and then hands over its
// result; a refused access goes from the region check straight to handing over
// its result.
// After reset the RAM is cleared one byte per cycle while no request is taken;
// configuration writes are taken during the clear.
// A stalled result sits in the output register while the next request is taken in
// and processed; it only waits at the end if the output register is still full.
`default_nettype none

module region_checked_byte_memory
    import rcbm_pkg::*;
#(
    parameter int MEM_BYTES = 65536,
    localparam int AW = $clog2(MEM_BYTES)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request stream.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [2:0] mode, [34:3] address,
                                                     // [66:35] write_data, [71:67] zero
    input  wire logic                 s_axis_tuser,  // [0] is_data
    // Result stream.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,  // [31:0] read_data
    output logic                      m_axis_tuser,  // [0] accepted
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_wdata
);

    // Last RAM address, end of the clearing pass.
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);
    // One past the last byte, for the end-of-memory check.
    localparam logic [32:0]   MEM_END  = 33'(MEM_BYTES);

    // Region registers.
    logic [31:0] r_text_start, r_data_start, r_heap_start, r_gp_start;

    // Controller state.
    t_state      r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;

    // Request held while it is processed.
    t_mode       r_mode, n_mode;
    logic [31:0] r_addr, n_addr;
    logic        r_is_data, n_is_data;
    logic [31:0] r_wdata, n_wdata;
    logic        r_ok, n_ok;
    logic        r_store, n_store;
    logic [1:0]  r_idx, n_idx;
    logic [1:0]  r_last, n_last;

    // Load assembly: a read issued last cycle lands in byte r_pidx.
    logic        r_pend, n_pend;
    logic [1:0]  r_pidx, n_pidx;
    logic [31:0] r_acc, n_acc;

    // Output register.
    logic        r_m_valid, n_m_valid;
    logic [31:0] r_m_data, n_m_data;
    logic        r_m_ok, n_m_ok;

    // RAM port.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic        in_accept;
    logic        out_free;
    logic        region_ok;
    logic        in_memory;
    logic [31:0] merged;
    logic [31:0] load_val;
    logic [31:0] result_val;

    rcbm_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_ok;

    // Only the start address is checked against the regions; an empty or
    // inverted region lets nothing through.
    always_comb begin
        if (r_is_data) begin
            region_ok = ((r_addr >= r_data_start) && (r_addr < r_heap_start)) ||
                        ((r_addr >= r_heap_start) && (r_addr < r_gp_start));
        end else begin
            region_ok = (r_addr >= r_text_start) && (r_addr < r_data_start);
        end
    end

    // The whole access has to fit inside the memory.
    assign in_memory = ({1'b0, r_addr} + 33'(mode_size_m1(r_mode)) + 33'd1) <= MEM_END;

    // Accumulated load value with the byte that the RAM returns this cycle.
    always_comb begin
        merged = r_acc;
        merged[{r_pidx, 3'b000} +: 8] = ram_rdata;
    end

    // Sign or zero extension of the assembled load.
    always_comb begin
        logic [31:0] v;
        v = r_pend ? merged : r_acc;
        case (r_mode)
            MODE_LB: load_val = {{24{v[7]}}, v[7:0]};
            MODE_LH: load_val = {{16{v[15]}}, v[15:0]};
            default: load_val = v;
        endcase
    end

    // Stores report zero; refused LBU/LHU loads report all ones at their width, others a full word of ones.
    always_comb begin
        if (r_store) begin
            result_val = '0;
        end else if (!r_ok) begin
            case (r_mode)
                MODE_LBU: result_val = REFUSE_BYTE;
                MODE_LHU: result_val = REFUSE_HALF;
                default:  result_val = REFUSE_WORD;
            endcase
        end else begin
            result_val = load_val;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (region_ok && in_memory) ? ST_RUN : ST_DONE;
            end
            ST_RUN: begin
                if (r_idx == r_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath, RAM port and output register.
    always_comb begin
        n_clr     = r_clr;
        n_mode    = r_mode;
        n_addr    = r_addr;
        n_is_data = r_is_data;
        n_wdata   = r_wdata;
        n_ok      = r_ok;
        n_store   = r_store;
        n_idx     = r_idx;
        n_last    = r_last;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_acc     = r_pend ? merged : r_acc;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        n_m_ok    = r_m_ok;

        ram_we    = 1'b0;
        ram_addr  = r_addr[AW-1:0] + AW'(r_idx);
        ram_wdata = r_wdata[{r_idx, 3'b000} +: 8];

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_mode    = t_mode'(s_axis_tdata[2:0]);
                    n_addr    = s_axis_tdata[34:3];
                    n_wdata   = s_axis_tdata[66:35];
                    n_is_data = s_axis_tuser;
                    n_acc     = '0;
                end
            end
            ST_CHECK: begin
                n_ok    = region_ok && in_memory;
                n_store = mode_is_store(r_mode);
                n_idx   = 2'd0;
                n_last  = mode_size_m1(r_mode);
            end
            ST_RUN: begin
                // One byte per cycle: write it, or read it and collect it next cycle.
                ram_we = r_store;
                n_pend = !r_store;
                n_pidx = r_idx;
                n_idx  = r_idx + 2'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = result_val;
                    n_m_ok    = r_ok;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_pend       <= 1'b0;
            r_m_valid    <= 1'b0;
            r_text_start <= '0;
            r_data_start <= '0;
            r_heap_start <= '0;
            r_gp_start   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEXT_START: r_text_start <= i_cfg_wdata;
                    CFG_DATA_START: r_data_start <= i_cfg_wdata;
                    CFG_HEAP_START: r_heap_start <= i_cfg_wdata;
                    CFG_GP_START:   r_gp_start   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_addr    <= n_addr;
        r_is_data <= n_is_data;
        r_wdata   <= n_wdata;
        r_ok      <= n_ok;
        r_store   <= n_store;
        r_idx     <= n_idx;
        r_last    <= n_last;
        r_pidx    <= n_pidx;
        r_acc     <= n_acc;
        r_m_data  <= n_m_data;
        r_m_ok    <= n_m_ok;
    end

    // A byte is written while processing a request only if the request passed its checks.
    a_store_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == ST_RUN)) |-> (r_ok && r_store))
        else $error("store byte written for a refused or non-store request");

    // The byte counter never passes the last byte of the access.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_idx <= r_last))
        else $error("byte counter ran past the access size");

    // A pending read byte always comes from a read issued in the previous cycle.
    a_pend_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == ST_RUN))
        else $error("pending read byte without a read");

    // A new result appears only out of the final state of a request.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result produced outside the final state");

    // No request is taken until the clearing pass is over.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> !($past(in_accept)))
        else $error("request taken during the clearing pass");

endmodule

`default_nettype wire

// File: sv/rcbm_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module rcbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire
